// File: rtl/etok_pkg.sv
// Shared types and codes for the expression tokenizer.
`default_nettype none

package etok_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LVL_W       = PTR_W + 1;

   localparam logic [3:0] KIND_NUMBER   = 4'd0;
   localparam logic [3:0] KIND_STRING   = 4'd1;
   localparam logic [3:0] KIND_VARIABLE = 4'd2;
   localparam logic [3:0] KIND_OPERATOR = 4'd3;
   localparam logic [3:0] KIND_LPAREN   = 4'd4;
   localparam logic [3:0] KIND_RPAREN   = 4'd5;
   localparam logic [3:0] KIND_COMMA    = 4'd6;
   localparam logic [3:0] KIND_END      = 4'd7;
   localparam logic [3:0] KIND_ERROR    = 4'd8;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EMPTY      = 3'd1;
   localparam logic [2:0] ERR_UNTERM     = 3'd2;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

   localparam logic [1:0] KW_NONE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_TRUE  = 2'd2;

   typedef struct packed {
      logic [3:0]  kind;
      logic [11:0] start;
      logic [12:0] length;
      logic [4:0]  opcode;
      logic [1:0]  kw_value;
      logic [2:0]  err_code;
      logic [7:0]  bad_char;
      logic        last;
   } tok_type;

   // Tokens written into the queue by one input item, tok0 first.
   typedef struct packed {
      logic [1:0] count;
      tok_type    tok1;
      tok_type    tok0;
   } push_type;

   typedef struct packed {
      logic             has_item;
      logic             has_room;
      logic [LVL_W-1:0] level;
   } qstat_type;

endpackage

`default_nettype wire

// File: rtl/etok_front.sv
// Lexer front end: classifies each character and forms up to two tokens per item.
`default_nettype none

module etok_front import etok_pkg::*; #(
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic [0:0] req_tuser,
   input  wire logic       room,
   output push_type        push
);

   localparam int POS_W = $clog2(MAX_LENGTH + 1);
   localparam int DW    = (POS_W > 13) ? POS_W : 13;
   localparam logic [11:0] LIMIT_START = 12'(MAX_LENGTH % 4096);

   localparam logic [3:0] HELD_NONE = 4'd15;

   localparam logic [7:0] CH_DOLLAR = "$";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_UNDER  = "_";

   typedef enum logic [5:0] {
      MODE_IDLE     = 6'b000001,
      MODE_NUMBER   = 6'b000010,
      MODE_STRING   = 6'b000100,
      MODE_VARIABLE = 6'b001000,
      MODE_IDENT    = 6'b010000,
      MODE_OPERATOR = 6'b100000
   } mode_type;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic [3:0] op_index(input logic [7:0] c);
      case (c)
         "+":     op_index = 4'd0;
         "-":     op_index = 4'd1;
         "*":     op_index = 4'd2;
         "/":     op_index = 4'd3;
         "%":     op_index = 4'd4;
         "<":     op_index = 4'd5;
         ">":     op_index = 4'd6;
         "=":     op_index = 4'd7;
         "!":     op_index = 4'd8;
         "&":     op_index = 4'd9;
         "|":     op_index = 4'd10;
         default: op_index = HELD_NONE;
      endcase
   endfunction

   // Code of a two-character operator, or zero when the pair does not combine.
   function automatic logic [4:0] pair_code(input logic [3:0] first, input logic [7:0] c);
      pair_code = 5'd0;
      if (c == "=") begin
         case (first)
            4'd7:    pair_code = 5'd11;
            4'd8:    pair_code = 5'd12;
            4'd5:    pair_code = 5'd13;
            4'd6:    pair_code = 5'd14;
            default: pair_code = 5'd0;
         endcase
      end else if ((c == "&") && (first == 4'd9)) begin
         pair_code = 5'd15;
      end else if ((c == "|") && (first == 4'd10)) begin
         pair_code = 5'd16;
      end
   endfunction

   // Prefix tracker: 1..4 follow "true", 5..9 follow "false".
   function automatic logic [3:0] kw_next(input logic [3:0] km, input logic [7:0] c);
      case (km)
         4'd1:    kw_next = (c == "r") ? 4'd2 : 4'd0;
         4'd2:    kw_next = (c == "u") ? 4'd3 : 4'd0;
         4'd3:    kw_next = (c == "e") ? 4'd4 : 4'd0;
         4'd5:    kw_next = (c == "a") ? 4'd6 : 4'd0;
         4'd6:    kw_next = (c == "l") ? 4'd7 : 4'd0;
         4'd7:    kw_next = (c == "s") ? 4'd8 : 4'd0;
         4'd8:    kw_next = (c == "e") ? 4'd9 : 4'd0;
         default: kw_next = 4'd0;
      endcase
   endfunction

   function automatic tok_type make_tok(input logic [3:0] kind, input logic [11:0] start,
                                        input logic [12:0] length, input logic [4:0] opcode,
                                        input logic [1:0] kw_value, input logic [2:0] err_code,
                                        input logic [7:0] bad_char);
      tok_type t;
      t.kind     = kind;
      t.start    = start;
      t.length   = length;
      t.opcode   = opcode;
      t.kw_value = kw_value;
      t.err_code = err_code;
      t.bad_char = bad_char;
      t.last     = 1'b0;
      make_tok   = t;
   endfunction

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] begin_ff, begin_in;
   logic [3:0]       held_ff, held_in;
   logic             dot_ff, dot_in;
   logic             single_ff, single_in;
   logic             escape_ff, escape_in;
   logic [3:0]       kw_ff, kw_in;
   logic             err_ff, err_in;

   logic             accept;
   logic [7:0]       c;
   logic [DW-1:0]    pos_w, beg_w, len_w, begm1_w;
   logic [POS_W-1:0] begm1;

   logic             flush_v;
   tok_type          flush_tok;
   logic             start_v;
   tok_type          start_tok;
   logic [3:0]       c_op;
   logic [4:0]       c_pair;
   logic [7:0]       close_quote;

   logic             first_v, second_v;
   tok_type          first_tok, second_tok;
   logic             restart;

   assign req_tready = room;
   assign accept     = req_tvalid && room;
   assign c          = req_tdata;

   assign begm1   = begin_ff - POS_W'(1);
   assign pos_w   = DW'(pos_ff);
   assign beg_w   = DW'(begin_ff);
   assign begm1_w = DW'(begm1);
   assign len_w   = pos_w - beg_w;

   assign c_op        = op_index(c);
   assign c_pair      = pair_code(held_ff, c);
   assign close_quote = single_ff ? CH_SQUOTE : CH_DQUOTE;

   // Token that closes the pending number, name or single operator.
   always_comb begin
      flush_v   = 1'b1;
      flush_tok = make_tok(KIND_NUMBER, beg_w[11:0], len_w[12:0], 5'd0, KW_NONE,
                           ERR_NONE, 8'd0);
      case (mode_ff)
         MODE_NUMBER: begin
         end
         MODE_VARIABLE: begin
            flush_tok.kind = KIND_VARIABLE;
         end
         MODE_IDENT: begin
            if (kw_ff == 4'd4) begin
               flush_tok.kw_value = KW_TRUE;
            end else if (kw_ff == 4'd9) begin
               flush_tok.kw_value = KW_FALSE;
            end else begin
               flush_tok.kind = KIND_VARIABLE;
            end
         end
         MODE_OPERATOR: begin
            flush_tok.kind   = KIND_OPERATOR;
            flush_tok.length = 13'd1;
            flush_tok.opcode = {1'b0, held_ff};
         end
         default: begin
            flush_v = 1'b0;
         end
      endcase
   end

   // Token that a character emits at once when it opens nothing.
   always_comb begin
      start_v   = 1'b1;
      start_tok = make_tok(KIND_LPAREN, pos_w[11:0], 13'd1, 5'd0, KW_NONE, ERR_NONE, 8'd0);
      if (c == CH_RPAREN) begin
         start_tok.kind = KIND_RPAREN;
      end else if (c == CH_COMMA) begin
         start_tok.kind = KIND_COMMA;
      end else if (c != CH_LPAREN) begin
         start_tok = make_tok(KIND_ERROR, pos_w[11:0], 13'd0, 5'd0, KW_NONE,
                              ERR_UNEXPECTED, c);
         start_v   = !(is_space(c) || is_digit(c) || is_alpha(c) || (c == CH_UNDER) ||
                       (c == CH_DOT) || (c == CH_DQUOTE) || (c == CH_SQUOTE) ||
                       (c == CH_DOLLAR) || (c_op != HELD_NONE));
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      begin_in   = begin_ff;
      held_in    = held_ff;
      dot_in     = dot_ff;
      single_in  = single_ff;
      escape_in  = escape_ff;
      kw_in      = kw_ff;
      err_in     = err_ff;
      first_v    = 1'b0;
      second_v   = 1'b0;
      first_tok  = flush_tok;
      second_tok = start_tok;
      restart    = 1'b0;

      if (accept) begin
         if (req_tuser[0]) begin
            if (!err_ff) begin
               first_v = 1'b1;
               if (pos_ff == '0) begin
                  first_tok = make_tok(KIND_ERROR, 12'd0, 13'd0, 5'd0, KW_NONE,
                                       ERR_EMPTY, 8'd0);
               end else if (dot_ff) begin
                  first_tok = make_tok(KIND_ERROR, beg_w[11:0], 13'd0, 5'd0, KW_NONE,
                                       ERR_UNEXPECTED, CH_DOT);
               end else if (mode_ff == MODE_STRING) begin
                  first_tok = make_tok(KIND_ERROR, begm1_w[11:0], 13'd0, 5'd0, KW_NONE,
                                       ERR_UNTERM, 8'd0);
               end else begin
                  first_v    = flush_v;
                  second_v   = 1'b1;
                  second_tok = make_tok(KIND_END, pos_w[11:0], 13'd0, 5'd0, KW_NONE,
                                        ERR_NONE, 8'd0);
               end
            end
            // The end marker always leaves the lexer as after reset.
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            begin_in  = '0;
            held_in   = HELD_NONE;
            dot_in    = 1'b0;
            single_in = 1'b0;
            escape_in = 1'b0;
            kw_in     = 4'd0;
            err_in    = 1'b0;
         end else if (!err_ff) begin
            if (pos_ff >= POS_W'(MAX_LENGTH)) begin
               first_v   = 1'b1;
               first_tok = make_tok(KIND_ERROR, LIMIT_START, 13'd0, 5'd0, KW_NONE,
                                    ERR_TOO_LONG, 8'd0);
               err_in    = 1'b1;
               mode_in   = MODE_IDLE;
               dot_in    = 1'b0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
               if (dot_ff) begin
                  dot_in = 1'b0;
                  if (is_digit(c)) begin
                     mode_in = MODE_NUMBER;
                  end else begin
                     first_v   = 1'b1;
                     first_tok = make_tok(KIND_ERROR, beg_w[11:0], 13'd0, 5'd0, KW_NONE,
                                          ERR_UNEXPECTED, CH_DOT);
                     err_in    = 1'b1;
                     mode_in   = MODE_IDLE;
                  end
               end else begin
                  case (mode_ff)
                     MODE_STRING: begin
                        if (escape_ff) begin
                           escape_in = 1'b0;
                        end else if (c == CH_BSLASH) begin
                           escape_in = 1'b1;
                        end else if (c == close_quote) begin
                           first_v   = 1'b1;
                           first_tok = make_tok(KIND_STRING, beg_w[11:0], len_w[12:0], 5'd0,
                                                KW_NONE, ERR_NONE, 8'd0);
                           mode_in   = MODE_IDLE;
                        end
                     end
                     MODE_NUMBER: begin
                        restart = !(is_digit(c) || (c == CH_DOT));
                     end
                     MODE_VARIABLE: begin
                        restart = !(is_digit(c) || is_alpha(c) || (c == CH_UNDER));
                     end
                     MODE_IDENT: begin
                        if (is_digit(c) || is_alpha(c) || (c == CH_UNDER)) begin
                           kw_in = kw_next(kw_ff, c);
                        end else begin
                           restart = 1'b1;
                        end
                     end
                     MODE_OPERATOR: begin
                        if (c_pair != 5'd0) begin
                           first_v   = 1'b1;
                           first_tok = make_tok(KIND_OPERATOR, beg_w[11:0], 13'd2, c_pair,
                                                KW_NONE, ERR_NONE, 8'd0);
                           mode_in   = MODE_IDLE;
                           held_in   = HELD_NONE;
                        end else begin
                           restart = 1'b1;
                        end
                     end
                     default: begin
                        restart = 1'b1;
                     end
                  endcase
               end

               if (restart) begin
                  first_v  = flush_v;
                  second_v = start_v;
                  mode_in  = MODE_IDLE;
                  held_in  = HELD_NONE;
                  kw_in    = 4'd0;
                  if (is_space(c)) begin
                  end else if (is_digit(c)) begin
                     mode_in  = MODE_NUMBER;
                     begin_in = pos_ff;
                  end else if (c == CH_DOT) begin
                     dot_in   = 1'b1;
                     begin_in = pos_ff;
                  end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                     mode_in   = MODE_STRING;
                     single_in = (c == CH_SQUOTE);
                     escape_in = 1'b0;
                     begin_in  = pos_ff + POS_W'(1);
                  end else if (c == CH_DOLLAR) begin
                     mode_in  = MODE_VARIABLE;
                     begin_in = pos_ff + POS_W'(1);
                  end else if (c_op != HELD_NONE) begin
                     mode_in  = MODE_OPERATOR;
                     held_in  = c_op;
                     begin_in = pos_ff;
                  end else if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA)) begin
                  end else if (is_alpha(c) || (c == CH_UNDER)) begin
                     mode_in  = MODE_IDENT;
                     begin_in = pos_ff;
                     kw_in    = (c == "t") ? 4'd1 : ((c == "f") ? 4'd5 : 4'd0);
                  end else begin
                     err_in = 1'b1;
                     dot_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Pack the emitted tokens into the queue write, marking the final one.
   always_comb begin
      push.tok0 = first_v ? first_tok : second_tok;
      push.tok1 = second_tok;
      push.tok0.last = !(first_v && second_v);
      push.tok1.last = 1'b1;
      push.count = (first_v && second_v) ? 2'd2 : ((first_v || second_v) ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         begin_ff  <= '0;
         held_ff   <= HELD_NONE;
         dot_ff    <= 1'b0;
         single_ff <= 1'b0;
         escape_ff <= 1'b0;
         kw_ff     <= 4'd0;
         err_ff    <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         held_ff   <= held_in;
         dot_ff    <= dot_in;
         single_ff <= single_in;
         escape_ff <= escape_in;
         kw_ff     <= kw_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/etok_queue.sv
// Token queue between lexer and output: two writes and one read per cycle.
`default_nettype none

module etok_queue import etok_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output tok_type       head,
   output qstat_type     stat
);

   tok_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0] wr_next;

   assign wr_next = wr_ff + PTR_W'(1);
   assign head    = mem_ff[rd_ff];

   assign stat.has_item = (level_ff != '0);
   assign stat.has_room = (level_ff <= LVL_W'(QUEUE_DEPTH - 2));
   assign stat.level    = level_ff;

   always_comb begin
      wr_in    = wr_ff + PTR_W'(push.count);
      rd_in    = pop ? (rd_ff + PTR_W'(1)) : rd_ff;
      level_in = level_ff + LVL_W'(push.count) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/etok_back.sv
// Output stage: takes tokens from the queue into the result register.
`default_nettype none

module etok_back import etok_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire tok_type head,
   input  wire logic    has_item,
   output logic         pop,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [47:0]  rsp_tdata,
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tlast
);

   logic    valid_ff, valid_in;
   tok_type tok_ff;

   assign pop      = has_item && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = tok_ff.kind;
   assign rsp_tlast  = tok_ff.last;
   assign rsp_tdata  = {5'd0, tok_ff.bad_char, tok_ff.err_code, tok_ff.kw_value,
                        tok_ff.opcode, tok_ff.length, tok_ff.start};

endmodule

`default_nettype wire

// File: rtl/expression_tokenizer_top.sv
// Top level of the streaming expression tokenizer.
`default_nettype none

// Characters enter one per item and an end-marker item closes the expression; tokens leave
// as start/length pairs with kind, operator code, keyword value and error details. The
// lexer takes one item per clock cycle while the queue has room and writes the zero, one
// or two tokens that item causes into a four-entry queue; the output register drains one
// token per cycle while the receiver is ready. Items that each cause one token thus flow
// at one item per cycle; each item that causes two tokens leaves one more in the queue,
// which absorbs them until it holds more than two tokens, at which point the input stalls.
module expression_tokenizer_top import etok_pkg::*; #(
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic [0:0]  req_tuser,   // [0] operation (1 = end of expression)
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] token_start, [24:12] token_length, [29:25] operator_code,
   // [31:30] keyword_value, [34:32] error_code, [42:35] bad_character, [47:43] zero
   output logic [47:0]      rsp_tdata,
   output logic [3:0]       rsp_tuser,   // [3:0] token_kind
   output logic             rsp_tlast    // last_result
);

   push_type  push;
   qstat_type q_stat;
   tok_type   head;
   logic      pop;

   etok_front #(
      .MAX_LENGTH(MAX_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .room       (q_stat.has_room),
      .push       (push)
   );

   etok_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (q_stat)
   );

   etok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .has_item   (q_stat.has_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) |-> (push.count == 2'd0))
      else $error("tokens written without an accepted item");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= LVL_W'(QUEUE_DEPTH))
      else $error("token queue overfilled");

   a_double_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.tok1.last && !push.tok0.last))
      else $error("last mark misplaced on a double write");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd1) |-> push.tok0.last)
      else $error("single token not marked last");

endmodule

`default_nettype wire

// File: tb/sv/expression_tokenizer_checker.sv
// Token predictor and scoreboard that watch both streams of the expression tokenizer.
`timescale 1ns / 100ps

module expression_tokenizer_checker
   import etok_pkg::*;
#(
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic [0:0]  req_tuser,   // [0] operation (1 = end of expression)
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] token_start, [24:12] token_length, [29:25] operator_code,
   // [31:30] keyword_value, [34:32] error_code, [42:35] bad_character, [47:43] zero
   input  wire logic [47:0] rsp_tdata,
   input  wire logic [3:0]  rsp_tuser,   // [3:0] token_kind
   input  wire logic        rsp_tlast,
   output int               mismatch_count,
   output int               tokens_owed
);

   typedef enum logic [5:0] {
      LEX_IDLE     = 6'b000001,
      LEX_NUMBER   = 6'b000010,
      LEX_STRING   = 6'b000100,
      LEX_VARIABLE = 6'b001000,
      LEX_WORD     = 6'b010000,
      LEX_OPERATOR = 6'b100000
   } lex_mode_type;

   localparam logic [4:0] OP_ADD     = 5'd0;
   localparam logic [4:0] OP_SUB     = 5'd1;
   localparam logic [4:0] OP_MUL     = 5'd2;
   localparam logic [4:0] OP_DIV     = 5'd3;
   localparam logic [4:0] OP_MOD     = 5'd4;
   localparam logic [4:0] OP_LT      = 5'd5;
   localparam logic [4:0] OP_GT      = 5'd6;
   localparam logic [4:0] OP_ASSIGN  = 5'd7;
   localparam logic [4:0] OP_NOT     = 5'd8;
   localparam logic [4:0] OP_BITAND  = 5'd9;
   localparam logic [4:0] OP_BITOR   = 5'd10;
   localparam logic [4:0] OP_EQ      = 5'd11;
   localparam logic [4:0] OP_NE      = 5'd12;
   localparam logic [4:0] OP_LE      = 5'd13;
   localparam logic [4:0] OP_GE      = 5'd14;
   localparam logic [4:0] OP_LOGAND  = 5'd15;
   localparam logic [4:0] OP_LOGOR   = 5'd16;
   localparam logic [4:0] OP_NONE    = 5'd31;
   localparam logic [4:0] NO_OP_CODE = 5'd0;

   // Progress through the letters of "true" and "false".
   localparam logic [3:0] KM_NONE  = 4'd0;
   localparam logic [3:0] KM_T     = 4'd1;
   localparam logic [3:0] KM_TR    = 4'd2;
   localparam logic [3:0] KM_TRU   = 4'd3;
   localparam logic [3:0] KM_TRUE  = 4'd4;
   localparam logic [3:0] KM_F     = 4'd5;
   localparam logic [3:0] KM_FA    = 4'd6;
   localparam logic [3:0] KM_FAL   = 4'd7;
   localparam logic [3:0] KM_FALS  = 4'd8;
   localparam logic [3:0] KM_FALSE = 4'd9;

   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_DOT    = ".";

   lex_mode_type lex_mode;
   logic [12:0]  char_pos;
   logic [12:0]  tok_begin;
   logic [4:0]   held_op;
   logic         dot_pending;
   logic         single_quote;
   logic         escape_pending;
   logic [3:0]   kw_state;
   logic         in_error;

   tok_type     staged[2];
   int          staged_cnt;
   tok_type     expected_tokens[$];
   int          fails = 0;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return is_digit(c) || is_alpha(c) || c == "_";
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [4:0] single_op(input logic [7:0] c);
      case (c)
         "+": return OP_ADD;
         "-": return OP_SUB;
         "*": return OP_MUL;
         "/": return OP_DIV;
         "%": return OP_MOD;
         "<": return OP_LT;
         ">": return OP_GT;
         "=": return OP_ASSIGN;
         "!": return OP_NOT;
         "&": return OP_BITAND;
         "|": return OP_BITOR;
         default: return OP_NONE;
      endcase
   endfunction

   function automatic logic [4:0] paired_op(input logic [4:0] first, input logic [7:0] c);
      if (c == "=") begin
         case (first)
            OP_ASSIGN: return OP_EQ;
            OP_NOT:    return OP_NE;
            OP_LT:     return OP_LE;
            OP_GT:     return OP_GE;
            default:   return OP_NONE;
         endcase
      end
      if (c == "&" && first == OP_BITAND) return OP_LOGAND;
      if (c == "|" && first == OP_BITOR) return OP_LOGOR;
      return OP_NONE;
   endfunction

   function automatic logic [3:0] kw_step(input logic [3:0] state, input logic [7:0] c);
      case (state)
         KM_T:    return (c == "r") ? KM_TR : KM_NONE;
         KM_TR:   return (c == "u") ? KM_TRU : KM_NONE;
         KM_TRU:  return (c == "e") ? KM_TRUE : KM_NONE;
         KM_F:    return (c == "a") ? KM_FA : KM_NONE;
         KM_FA:   return (c == "l") ? KM_FAL : KM_NONE;
         KM_FAL:  return (c == "s") ? KM_FALS : KM_NONE;
         KM_FALS: return (c == "e") ? KM_FALSE : KM_NONE;
         default: return KM_NONE;
      endcase
   endfunction

   function automatic int field_check(input string name, input logic [12:0] want,
                                      input logic [12:0] got);
      if (want !== got) begin
         $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic clear_state();
      lex_mode       = LEX_IDLE;
      char_pos       = '0;
      tok_begin      = '0;
      held_op        = OP_NONE;
      dot_pending    = 1'b0;
      single_quote   = 1'b0;
      escape_pending = 1'b0;
      kw_state       = KM_NONE;
      in_error       = 1'b0;
   endtask

   // At most two tokens can come out of one item; anything beyond is dropped.
   task automatic stage(input logic [3:0] kind, input logic [12:0] start,
                        input logic [12:0] len, input logic [4:0] opc, input logic [1:0] kw,
                        input logic [2:0] err, input logic [7:0] bad);
      tok_type t;
      if (staged_cnt < 2) begin
         t.kind     = kind;
         t.start    = start[11:0];
         t.length   = len;
         t.opcode   = opc;
         t.kw_value = kw;
         t.err_code = err;
         t.bad_char = bad;
         t.last     = 1'b0;
         staged[staged_cnt] = t;
         staged_cnt++;
      end
   endtask

   task automatic raise_fault(input logic [2:0] err, input logic [12:0] where,
                              input logic [7:0] bad);
      stage(KIND_ERROR, where, 13'd0, NO_OP_CODE, KW_NONE, err, bad);
      in_error    = 1'b1;
      lex_mode    = LEX_IDLE;
      dot_pending = 1'b0;
   endtask

   // Emits whatever token is still open, ending just before pos.
   task automatic flush_pending(input logic [12:0] pos);
      logic [12:0] len;
      len = pos - tok_begin;
      case (lex_mode)
         LEX_NUMBER: stage(KIND_NUMBER, tok_begin, len, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
         LEX_VARIABLE: stage(KIND_VARIABLE, tok_begin, len, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
         LEX_WORD: begin
            if (kw_state == KM_TRUE)
               stage(KIND_NUMBER, tok_begin, len, NO_OP_CODE, KW_TRUE, ERR_NONE, 8'd0);
            else if (kw_state == KM_FALSE)
               stage(KIND_NUMBER, tok_begin, len, NO_OP_CODE, KW_FALSE, ERR_NONE, 8'd0);
            else
               stage(KIND_VARIABLE, tok_begin, len, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
         end
         LEX_OPERATOR: stage(KIND_OPERATOR, tok_begin, 13'd1, held_op, KW_NONE, ERR_NONE, 8'd0);
         default: ;
      endcase
      lex_mode = LEX_IDLE;
      held_op  = OP_NONE;
      kw_state = KM_NONE;
   endtask

   task automatic begin_token(input logic [7:0] c, input logic [12:0] pos);
      logic [4:0] opc;
      opc = single_op(c);
      if (is_space(c)) begin
      end else if (is_digit(c)) begin
         lex_mode  = LEX_NUMBER;
         tok_begin = pos;
      end else if (c == CH_DOT) begin
         dot_pending = 1'b1;
         tok_begin   = pos;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         lex_mode       = LEX_STRING;
         single_quote   = (c == CH_SQUOTE);
         escape_pending = 1'b0;
         tok_begin      = pos + 13'd1;
      end else if (c == "$") begin
         lex_mode  = LEX_VARIABLE;
         tok_begin = pos + 13'd1;
      end else if (opc != OP_NONE) begin
         lex_mode  = LEX_OPERATOR;
         held_op   = opc;
         tok_begin = pos;
      end else if (c == "(") begin
         stage(KIND_LPAREN, pos, 13'd1, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
      end else if (c == ")") begin
         stage(KIND_RPAREN, pos, 13'd1, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
      end else if (c == ",") begin
         stage(KIND_COMMA, pos, 13'd1, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
      end else if (is_alpha(c) || c == "_") begin
         lex_mode  = LEX_WORD;
         tok_begin = pos;
         kw_state  = (c == "t") ? KM_T : ((c == "f") ? KM_F : KM_NONE);
      end else begin
         raise_fault(ERR_UNEXPECTED, pos, c);
      end
   endtask

   task automatic consume_char(input logic [7:0] c, input logic [12:0] pos);
      logic [4:0] pc;
      logic       kept;
      if (dot_pending) begin
         // A leading dot becomes a number only when a digit follows it.
         dot_pending = 1'b0;
         if (is_digit(c))
            lex_mode = LEX_NUMBER;
         else
            raise_fault(ERR_UNEXPECTED, tok_begin, CH_DOT);
      end else begin
         kept = 1'b0;
         case (lex_mode)
            LEX_STRING: begin
               kept = 1'b1;
               if (escape_pending) begin
                  escape_pending = 1'b0;
               end else if (c == "\\") begin
                  escape_pending = 1'b1;
               end else if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                  stage(KIND_STRING, tok_begin, pos - tok_begin, NO_OP_CODE, KW_NONE,
                        ERR_NONE, 8'd0);
                  lex_mode = LEX_IDLE;
               end
            end
            LEX_NUMBER: kept = is_digit(c) || c == CH_DOT;
            LEX_VARIABLE: kept = is_word(c);
            LEX_WORD: begin
               if (is_word(c)) begin
                  kw_state = kw_step(kw_state, c);
                  kept     = 1'b1;
               end
            end
            LEX_OPERATOR: begin
               pc = paired_op(held_op, c);
               if (pc != OP_NONE) begin
                  stage(KIND_OPERATOR, tok_begin, 13'd2, pc, KW_NONE, ERR_NONE, 8'd0);
                  lex_mode = LEX_IDLE;
                  held_op  = OP_NONE;
                  kept     = 1'b1;
               end
            end
            default: ;
         endcase
         if (!kept) begin
            flush_pending(pos);
            begin_token(c, pos);
         end
      end
   endtask

   task automatic predict_tokens(input logic end_marker, input logic [7:0] c);
      logic [12:0] pos;
      tok_type     t;
      int          i;
      staged_cnt = 0;
      if (end_marker) begin
         if (!in_error) begin
            if (char_pos == 13'd0)
               raise_fault(ERR_EMPTY, 13'd0, 8'd0);
            else if (dot_pending)
               raise_fault(ERR_UNEXPECTED, tok_begin, CH_DOT);
            else if (lex_mode == LEX_STRING)
               raise_fault(ERR_UNTERM, tok_begin - 13'd1, 8'd0);
            else begin
               flush_pending(char_pos);
               stage(KIND_END, char_pos, 13'd0, NO_OP_CODE, KW_NONE, ERR_NONE, 8'd0);
            end
         end
         clear_state();
      end else if (!in_error) begin
         if (char_pos >= MAX_LENGTH) begin
            raise_fault(ERR_TOO_LONG, 13'(MAX_LENGTH), 8'd0);
         end else begin
            pos      = char_pos;
            char_pos = pos + 13'd1;
            consume_char(c, pos);
         end
      end
      for (i = 0; i < staged_cnt; i++) begin
         t      = staged[i];
         t.last = (i == staged_cnt - 1);
         expected_tokens = {expected_tokens, t};
      end
   endtask

   always @(posedge clock) begin
      tok_type got;
      tok_type want;
      int      bad_fields;
      if (reset) begin
         clear_state();
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind     = rsp_tuser;
            got.start    = rsp_tdata[11:0];
            got.length   = rsp_tdata[24:12];
            got.opcode   = rsp_tdata[29:25];
            got.kw_value = rsp_tdata[31:30];
            got.err_code = rsp_tdata[34:32];
            got.bad_char = rsp_tdata[42:35];
            got.last     = rsp_tlast;
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected token, expected none, actual %p", $time, got);
               fails++;
            end else begin
               want = expected_tokens.pop_front();
               bad_fields = field_check("kind", 13'(want.kind), 13'(got.kind))
                          + field_check("start", 13'(want.start), 13'(got.start))
                          + field_check("length", want.length, got.length)
                          + field_check("operator_code", 13'(want.opcode), 13'(got.opcode))
                          + field_check("keyword_value", 13'(want.kw_value),
                                        13'(got.kw_value))
                          + field_check("error_code", 13'(want.err_code), 13'(got.err_code))
                          + field_check("bad_character", 13'(want.bad_char),
                                        13'(got.bad_char))
                          + field_check("last", 13'(want.last), 13'(got.last))
                          + field_check("padding", 13'd0, 13'(rsp_tdata[47:43]));
               if (bad_fields != 0)
                  fails++;
            end
         end
         if (req_tvalid && req_tready)
            predict_tokens(req_tuser[0], req_tdata);
      end
      mismatch_count <= fails;
      tokens_owed    <= expected_tokens.size();
   end

endmodule

// File: tb/sv/tb_expression_tokenizer_top.sv
// Stimulus, flow control and verdict for the expression tokenizer testbench.
`timescale 1ns / 100ps

module tb_expression_tokenizer_top;
   import etok_pkg::*;

   localparam int   MAX_LENGTH   = 4096;
   localparam int   CYCLE_LIMIT  = 100000;
   localparam int   RANDOM_ITEMS = 550;
   localparam int   HOLD_CYCLES  = 300;
   localparam logic ITEM_CHAR    = 1'b0;
   localparam logic ITEM_END     = 1'b1;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] character
   logic [0:0]  req_tuser;    // [0] operation (1 = end of expression)
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [11:0] start, [24:12] length, [29:25] operator, [31:30] keyword,
                              // [34:32] error, [42:35] bad character, [47:43] zero
   logic [3:0]  rsp_tuser;    // [3:0] token_kind
   logic        rsp_tlast;

   int          mismatch_count;
   int          tokens_owed;
   int          cycle_count = 0;
   bit          long_hold = 1'b0;
   bit          tx_nogap = 1'b0;
   bit          rx_nostall = 1'b0;
   logic [7:0]  text_q[$];

   expression_tokenizer_top #(
      .MAX_LENGTH (MAX_LENGTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   expression_tokenizer_checker #(
      .MAX_LENGTH (MAX_LENGTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .tokens_owed    (tokens_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("expression_tokenizer_top verification failed");
         $finish;
      end
   end

   // Result side: a random stall before each token, with occasional stall-free stretches
   // and one long hold-off that lets the block back up into its input.
   initial begin
      int stall;
      int served;
      served = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            stall = rx_nostall ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         served++;
         if (served % 30 == 0)
            rx_nostall = ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] ch);
      int gap;
      gap = tx_nogap ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sends the queued characters followed by the end marker.
   task automatic send_text();
      int i;
      for (i = 0; i < text_q.size(); i++)
         send_item(ITEM_CHAR, text_q[i]);
      send_item(ITEM_END, 8'($urandom_range(0, 255)));
      text_q.delete();
   endtask

   task automatic add_char(input logic [7:0] ch);
      text_q = {text_q, ch};
   endtask

   task automatic add_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         add_char(s[i]);
   endtask

   // The input goes idle while the sender waits for every owed token.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tokens_owed != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_alpha();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] pick_word();
      if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
      return pick_alpha();
   endfunction

   // Builds one expression from random tokens. Most of it is well formed; a few tokens
   // break it, after which the block ignores the rest of the expression.
   task automatic build_expr();
      string      op_set;
      int         n_tok;
      int         k;
      int         i;
      int         len;
      int         kind;
      logic [7:0] q;
      op_set = "+-*/%<>=!&|";
      text_q.delete();
      n_tok = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
      for (k = 0; k < n_tok; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            if ($urandom_range(0, 4) == 0) add_char(".");
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) begin
               add_char(8'("0" + $urandom_range(0, 9)));
               if (i == 0 && $urandom_range(0, 4) == 0) add_char(".");
            end
         end else if (kind < 25) begin
            q = $urandom_range(0, 1) ? "'" : "\"";
            add_char(q);
            len = $urandom_range(0, 6);
            for (i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0: begin
                     add_char("\\");
                     add_char(8'($urandom_range(0, 255)));
                  end
                  1: add_char(8'($urandom_range(0, 255)));
                  default: add_char(pick_alpha());
               endcase
            end
            if ($urandom_range(0, 9) != 0) add_char(q);
         end else if (kind < 35) begin
            add_char("$");
            len = $urandom_range(0, 5);
            for (i = 0; i < len; i++) add_char(pick_word());
         end else if (kind < 50) begin
            case ($urandom_range(0, 5))
               0: add_str("true");
               1: add_str("false");
               2: add_str("tru");
               3: add_str("falsex");
               4: add_str("t_1");
               default: begin
                  add_char(pick_alpha());
                  len = $urandom_range(0, 5);
                  for (i = 0; i < len; i++) add_char(pick_word());
               end
            endcase
         end else if (kind < 70) begin
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 5))
                  0: add_str("==");
                  1: add_str("!=");
                  2: add_str("<=");
                  3: add_str(">=");
                  4: add_str("&&");
                  default: add_str("||");
               endcase
            end else begin
               add_char(op_set[$urandom_range(0, 10)]);
               if ($urandom_range(0, 4) < 2) add_char(op_set[$urandom_range(0, 10)]);
            end
         end else if (kind < 80) begin
            case ($urandom_range(0, 2))
               0: add_char("(");
               1: add_char(")");
               default: add_char(",");
            endcase
         end else if (kind < 92) begin
            len = $urandom_range(0, 5);
            add_char((len == 5) ? 8'd32 : 8'(9 + len));
         end else if (kind < 96) begin
            add_char(".");
            add_char(pick_alpha());
         end else begin
            add_char(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 1)) add_char(" ");
      end
   endtask

   initial begin
      int random_items;
      int n_expr;
      int i;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tuser  <= ITEM_CHAR;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty and blank expressions, a dot with no digit, a string whose
      // closing quote is escaped, a high byte, and both keywords around a comma.
      send_text();
      add_str("\t");
      send_text();
      add_str(".)");
      send_text();
      add_str("'\\'");
      send_text();
      add_char(8'hFF);
      send_text();
      add_str("true,false");
      send_text();

      random_items = 0;
      n_expr = 0;
      while (random_items < RANDOM_ITEMS) begin
         tx_nogap = ($urandom_range(0, 5) == 0);
         if (n_expr == 4) begin
            // Receiver stops for a long while; a gapless burst fills the output queue.
            wait_drained();
            long_hold = 1'b1;
            tx_nogap = 1'b1;
            for (i = 0; i < 24; i++) begin
               case ($urandom_range(0, 2))
                  0: add_char("(");
                  1: add_char(")");
                  default: add_char(",");
               endcase
            end
            random_items += 25;
            send_text();
         end else begin
            if (n_expr % 15 == 10) wait_drained();
            build_expr();
            random_items += text_q.size() + 1;
            send_text();
         end
         n_expr++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("expression_tokenizer_top verification clean");
      else
         $display("expression_tokenizer_top verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/etok_pkg.sv
rtl/etok_front.sv
rtl/etok_queue.sv
rtl/etok_back.sv
rtl/expression_tokenizer_top.sv
tb/sv/expression_tokenizer_checker.sv
tb/sv/tb_expression_tokenizer_top.sv
